// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and types for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    localparam int WORD_W   = 32;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int COEF_W   = PROD_W + 2;
    localparam int SPLIT_W  = COEF_W / 2;
    localparam int LO_W     = SPLIT_W + 1 + WORD_W;
    localparam int HI_W     = (COEF_W - SPLIT_W) + WORD_W;
    localparam int LOSUM_W  = LO_W + 2;
    localparam int HISUM_W  = HI_W + 2;
    localparam int ACC_W    = 101;
    localparam int FRAC_SH  = 60;
    localparam int SHIFT_W  = ACC_W - FRAC_SH;
    localparam int AXES     = 3;
    localparam int TERMS    = 3;

    localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) <<< (FRAC_SH - 1);
    localparam logic signed [SHIFT_W-1:0] SAT_MAX    = SHIFT_W'(64'sh7FFFFFFF);
    localparam logic signed [SHIFT_W-1:0] SAT_MIN    = SHIFT_W'(-64'sh80000000);

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [LOSUM_W-1:0] losum_t;
    typedef logic signed [HISUM_W-1:0] hisum_t;

endpackage

`default_nettype wire

// ===== rtl/qvr_coef.sv =====
// ----------------------------------------------------------------------------
// qvr_coef
// Stages 1-2: pairwise quaternion products, then the rotation matrix
// coefficients (scaled by 2 off the diagonal).
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_coef (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qvr_pkg::word_t  vec_in [qvr_pkg::AXES],
    input  wire qvr_pkg::word_t  quat_w,
    input  wire qvr_pkg::word_t  quat_x,
    input  wire qvr_pkg::word_t  quat_y,
    input  wire qvr_pkg::word_t  quat_z,
    output logic                 out_valid,
    input  wire logic            down_ready,
    output qvr_pkg::word_t       vec_out [qvr_pkg::AXES],
    output qvr_pkg::coef_t       coef [qvr_pkg::AXES][qvr_pkg::TERMS]
);

    logic           v1_reg;
    logic           v2_reg;
    logic           rdy1;
    logic           rdy2;
    qvr_pkg::prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    qvr_pkg::prod_t xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    qvr_pkg::word_t vec1_reg [qvr_pkg::AXES];
    qvr_pkg::word_t vec2_reg [qvr_pkg::AXES];
    qvr_pkg::coef_t coef_reg [qvr_pkg::AXES][qvr_pkg::TERMS];
    qvr_pkg::coef_t coef_next [qvr_pkg::AXES][qvr_pkg::TERMS];
    qvr_pkg::coef_t ww_e, xx_e, yy_e, zz_e;

    assign rdy2     = !v2_reg || down_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        ww_e = qvr_pkg::COEF_W'(ww_reg);
        xx_e = qvr_pkg::COEF_W'(xx_reg);
        yy_e = qvr_pkg::COEF_W'(yy_reg);
        zz_e = qvr_pkg::COEF_W'(zz_reg);
        coef_next[qvr_pkg::AX_X][0] = ww_e + xx_e - yy_e - zz_e;
        coef_next[qvr_pkg::AX_Y][0] = ww_e - xx_e + yy_e - zz_e;
        coef_next[qvr_pkg::AX_Z][0] = ww_e - xx_e - yy_e + zz_e;
        coef_next[qvr_pkg::AX_X][1] =
            (qvr_pkg::COEF_W'(xy_reg) - qvr_pkg::COEF_W'(wz_reg)) <<< 1;
        coef_next[qvr_pkg::AX_X][2] =
            (qvr_pkg::COEF_W'(xz_reg) + qvr_pkg::COEF_W'(wy_reg)) <<< 1;
        coef_next[qvr_pkg::AX_Y][1] =
            (qvr_pkg::COEF_W'(xy_reg) + qvr_pkg::COEF_W'(wz_reg)) <<< 1;
        coef_next[qvr_pkg::AX_Y][2] =
            (qvr_pkg::COEF_W'(yz_reg) - qvr_pkg::COEF_W'(wx_reg)) <<< 1;
        coef_next[qvr_pkg::AX_Z][1] =
            (qvr_pkg::COEF_W'(xz_reg) - qvr_pkg::COEF_W'(wy_reg)) <<< 1;
        coef_next[qvr_pkg::AX_Z][2] =
            (qvr_pkg::COEF_W'(yz_reg) + qvr_pkg::COEF_W'(wx_reg)) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            ww_reg   <= quat_w * quat_w;
            xx_reg   <= quat_x * quat_x;
            yy_reg   <= quat_y * quat_y;
            zz_reg   <= quat_z * quat_z;
            xy_reg   <= quat_x * quat_y;
            xz_reg   <= quat_x * quat_z;
            yz_reg   <= quat_y * quat_z;
            wx_reg   <= quat_w * quat_x;
            wy_reg   <= quat_w * quat_y;
            wz_reg   <= quat_w * quat_z;
            vec1_reg <= vec_in;
        end
        if (rdy2 && v1_reg)
        begin
            coef_reg <= coef_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign vec_out   = vec2_reg;
    assign coef      = coef_reg;

endmodule

`default_nettype wire

// ===== rtl/qvr_mac.sv =====
// ----------------------------------------------------------------------------
// qvr_mac
// Stages 3-4: coefficient times vector component as two split partial
// products, then per-axis sums of the low and high halves.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qvr_pkg::word_t  vec_in [qvr_pkg::AXES],
    input  wire qvr_pkg::coef_t  coef [qvr_pkg::AXES][qvr_pkg::TERMS],
    output logic                 out_valid,
    input  wire logic            down_ready,
    output qvr_pkg::losum_t      lo_sum [qvr_pkg::AXES],
    output qvr_pkg::hisum_t      hi_sum [qvr_pkg::AXES]
);

    localparam int SW = qvr_pkg::SPLIT_W;

    logic                                 v3_reg;
    logic                                 v4_reg;
    logic                                 rdy3;
    logic                                 rdy4;
    logic signed [qvr_pkg::LO_W-1:0]      plo_reg [qvr_pkg::AXES][qvr_pkg::TERMS];
    logic signed [qvr_pkg::HI_W-1:0]      phi_reg [qvr_pkg::AXES][qvr_pkg::TERMS];
    logic signed [qvr_pkg::LO_W-1:0]      plo_next [qvr_pkg::AXES][qvr_pkg::TERMS];
    logic signed [qvr_pkg::HI_W-1:0]      phi_next [qvr_pkg::AXES][qvr_pkg::TERMS];
    qvr_pkg::word_t                       vsel [qvr_pkg::AXES][qvr_pkg::TERMS];
    qvr_pkg::losum_t                      lo_reg [qvr_pkg::AXES];
    qvr_pkg::hisum_t                      hi_reg [qvr_pkg::AXES];
    qvr_pkg::losum_t                      lo_next [qvr_pkg::AXES];
    qvr_pkg::hisum_t                      hi_next [qvr_pkg::AXES];

    assign rdy4     = !v4_reg || down_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_comb
    begin
        vsel[qvr_pkg::AX_X][0] = vec_in[qvr_pkg::AX_X];
        vsel[qvr_pkg::AX_X][1] = vec_in[qvr_pkg::AX_Y];
        vsel[qvr_pkg::AX_X][2] = vec_in[qvr_pkg::AX_Z];
        vsel[qvr_pkg::AX_Y][0] = vec_in[qvr_pkg::AX_Y];
        vsel[qvr_pkg::AX_Y][1] = vec_in[qvr_pkg::AX_X];
        vsel[qvr_pkg::AX_Y][2] = vec_in[qvr_pkg::AX_Z];
        vsel[qvr_pkg::AX_Z][0] = vec_in[qvr_pkg::AX_Z];
        vsel[qvr_pkg::AX_Z][1] = vec_in[qvr_pkg::AX_X];
        vsel[qvr_pkg::AX_Z][2] = vec_in[qvr_pkg::AX_Y];
        for (int a = 0; a < qvr_pkg::AXES; a++)
        begin
            for (int t = 0; t < qvr_pkg::TERMS; t++)
            begin
                plo_next[a][t] = $signed({1'b0, coef[a][t][SW-1:0]}) * vsel[a][t];
                phi_next[a][t] = $signed(coef[a][t][qvr_pkg::COEF_W-1:SW]) * vsel[a][t];
            end
        end
        for (int a = 0; a < qvr_pkg::AXES; a++)
        begin
            lo_next[a] = qvr_pkg::LOSUM_W'(plo_reg[a][0]) + qvr_pkg::LOSUM_W'(plo_reg[a][1])
                       + qvr_pkg::LOSUM_W'(plo_reg[a][2]);
            hi_next[a] = qvr_pkg::HISUM_W'(phi_reg[a][0]) + qvr_pkg::HISUM_W'(phi_reg[a][1])
                       + qvr_pkg::HISUM_W'(phi_reg[a][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (rdy4 && v3_reg)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign out_valid = v4_reg;
    assign lo_sum    = lo_reg;
    assign hi_sum    = hi_reg;

endmodule

`default_nettype wire

// ===== rtl/qvr_round.sv =====
// ----------------------------------------------------------------------------
// qvr_round
// Stages 5-6: merge the split sums with the rounding half, then shift to
// Q16.16 and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_round (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire qvr_pkg::losum_t  lo_sum [qvr_pkg::AXES],
    input  wire qvr_pkg::hisum_t  hi_sum [qvr_pkg::AXES],
    output logic                  out_valid,
    input  wire logic             out_ready,
    output qvr_pkg::word_t        rot [qvr_pkg::AXES]
);

    logic                                v5_reg;
    logic                                v6_reg;
    logic                                rdy5;
    logic                                rdy6;
    logic signed [qvr_pkg::ACC_W-1:0]    acc_reg [qvr_pkg::AXES];
    logic signed [qvr_pkg::ACC_W-1:0]    acc_next [qvr_pkg::AXES];
    logic signed [qvr_pkg::SHIFT_W-1:0]  sh [qvr_pkg::AXES];
    qvr_pkg::word_t                      rot_reg [qvr_pkg::AXES];
    qvr_pkg::word_t                      rot_next [qvr_pkg::AXES];

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    always_comb
    begin
        for (int a = 0; a < qvr_pkg::AXES; a++)
        begin
            acc_next[a] = (qvr_pkg::ACC_W'(hi_sum[a]) <<< qvr_pkg::SPLIT_W)
                        + qvr_pkg::ACC_W'(lo_sum[a]) + qvr_pkg::ROUND_HALF;
            sh[a] = acc_reg[a][qvr_pkg::ACC_W-1:qvr_pkg::FRAC_SH];
            if (sh[a] > qvr_pkg::SAT_MAX)
            begin
                rot_next[a] = qvr_pkg::SAT_MAX[qvr_pkg::WORD_W-1:0];
            end
            else if (sh[a] < qvr_pkg::SAT_MIN)
            begin
                rot_next[a] = qvr_pkg::SAT_MIN[qvr_pkg::WORD_W-1:0];
            end
            else
            begin
                rot_next[a] = sh[a][qvr_pkg::WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy5)
            begin
                v5_reg <= in_valid;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && in_valid)
        begin
            acc_reg <= acc_next;
        end
        if (rdy6 && v5_reg)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = v6_reg;
    assign rot       = rot_reg;

endmodule

`default_nettype wire

// ===== rtl/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 vector by a Q2.30 quaternion: vector part of q*(0,v)*q'.
// ----------------------------------------------------------------------------
// Six-stage pipeline: an item accepted on s_axis moves through the stage
// registers in order and is offered on m_axis from the last one; a new item
// is taken every cycle while the output is not stalled.
// The stages are: pairwise quaternion products, matrix coefficients, split
// coefficient-by-component products, per-axis partial sums, merge with
// rounding, then shift and saturate. The quaternion is not normalized, so a
// non-unit q scales the result by |q|^2. Results round to nearest with ties
// toward +infinity and saturate to the 32-bit range. A stage holds its item
// while the stage after it is full and stalled; empty stages fill, so the
// input stays ready while any stage has a free slot.
`default_nettype none

module quaternion_vector_rotate (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [223:0]  s_axis_tdata,   // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [95:0]        m_axis_tdata    // rot_x, rot_y, rot_z
);

    localparam int W = qvr_pkg::WORD_W;

    qvr_pkg::word_t  vec_in [qvr_pkg::AXES];
    qvr_pkg::word_t  vec_c [qvr_pkg::AXES];
    qvr_pkg::coef_t  coef [qvr_pkg::AXES][qvr_pkg::TERMS];
    qvr_pkg::losum_t lo_sum [qvr_pkg::AXES];
    qvr_pkg::hisum_t hi_sum [qvr_pkg::AXES];
    qvr_pkg::word_t  rot [qvr_pkg::AXES];
    logic            coef_valid;
    logic            mac_valid;
    logic            mac_ready;
    logic            rnd_ready;

    assign vec_in[qvr_pkg::AX_X] = s_axis_tdata[0*W +: W];
    assign vec_in[qvr_pkg::AX_Y] = s_axis_tdata[1*W +: W];
    assign vec_in[qvr_pkg::AX_Z] = s_axis_tdata[2*W +: W];

    qvr_coef u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .vec_in     (vec_in),
        .quat_w     (s_axis_tdata[3*W +: W]),
        .quat_x     (s_axis_tdata[4*W +: W]),
        .quat_y     (s_axis_tdata[5*W +: W]),
        .quat_z     (s_axis_tdata[6*W +: W]),
        .out_valid  (coef_valid),
        .down_ready (mac_ready),
        .vec_out    (vec_c),
        .coef       (coef)
    );

    qvr_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (coef_valid),
        .in_ready   (mac_ready),
        .vec_in     (vec_c),
        .coef       (coef),
        .out_valid  (mac_valid),
        .down_ready (rnd_ready),
        .lo_sum     (lo_sum),
        .hi_sum     (hi_sum)
    );

    qvr_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mac_valid),
        .in_ready   (rnd_ready),
        .lo_sum     (lo_sum),
        .hi_sum     (hi_sum),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .rot        (rot)
    );

    assign m_axis_tdata = {rot[qvr_pkg::AX_Z], rot[qvr_pkg::AX_Y], rot[qvr_pkg::AX_X]};

endmodule

`default_nettype wire

// ===== rtl/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks for quaternion_vector_rotate, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_axis_tready,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [95:0]   m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output stage");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

`default_nettype wire
